/* hw/rtl/efd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efd_pkg
// constants and arctangent table for the forward direction pipeline
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_BITS  = 34;

    typedef logic signed [CORDIC_BITS-1:0] t_cval;

    localparam t_cval CORDIC_GAIN = 34'sh026DD3B6A;
    localparam t_cval QUARTER     = 34'sh040000000;
    localparam t_cval HALF        = 34'sh080000000;

    function automatic t_cval atan_turn(input int idx);
        t_cval v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            23: v = 34'sh000000051;
            24: v = 34'sh000000029;
            25: v = 34'sh000000014;
            26: v = 34'sh00000000A;
            27: v = 34'sh000000005;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/efd_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efd_cordic
// pipelined rotation-mode cordic, one step per stage, sine and cosine in q30
// ----------------------------------------------------------------------------
module efd_cordic
    import efd_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output logic                       o_valid,
    output t_cval                      o_sin,
    output t_cval                      o_cos
);

    localparam int NS = CORDIC_STEPS;

    logic        r_v [NS+2];
    t_cval       r_x [NS+1];
    t_cval       r_y [NS+1];
    t_cval       r_z [NS+1];
    logic        r_neg [NS+1];
    t_cval       r_s;
    t_cval       r_c;

    logic [31:0] w_turn;
    t_cval       w_z;
    t_cval       n_z;
    logic        n_neg;

    assign w_turn = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_z    = {{2{w_turn[31]}}, w_turn};

    always_comb begin
        n_z   = w_z;
        n_neg = 1'b0;
        if (w_z > QUARTER) begin
            n_z   = w_z - HALF;
            n_neg = 1'b1;
        end else if (w_z < -QUARTER) begin
            n_z   = w_z + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS + 2; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS + 2; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= n_z;
        r_neg[0] <= n_neg;
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_step
            always_ff @(posedge i_clk) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][CORDIC_BITS-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_turn(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_turn(g);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_c <= r_neg[NS] ? -r_x[NS] : r_x[NS];
        r_s <= r_neg[NS] ? -r_y[NS] : r_y[NS];
    end

    assign o_valid = r_v[NS+1];
    assign o_sin   = r_s;
    assign o_cos   = r_c;

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_z[0] <= QUARTER && r_z[0] >= -QUARTER))
        else $error("folded angle out of range");

    a_gain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_x[0] == CORDIC_GAIN && r_y[0] == '0))
        else $error("bad start vector");

    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> $past(r_v[0]))
        else $error("valid chain broken");

endmodule
`default_nettype wire

/* hw/rtl/euler_forward_direction.sv */
`default_nettype none
// throughput: one beat per cycle, busy is never raised
// the fold register, 28 cordic stages, sign fix and four arithmetic stages set the latency
// reset is synchronous, active low, and clears only the valid bits
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// euler_forward_direction
// world direction of the local forward axis from roll, pitch and yaw
// ----------------------------------------------------------------------------
module euler_forward_direction
    import efd_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ANGLE_BITS-1:0] i_roll_angle,
    input  wire logic [ANGLE_BITS-1:0] i_pitch_angle,
    input  wire logic [ANGLE_BITS-1:0] i_yaw_angle,
    output logic                       o_valid,
    output logic signed [FRAC_BITS+1:0] o_dir_x,
    output logic signed [FRAC_BITS+1:0] o_dir_y,
    output logic signed [FRAC_BITS+1:0] o_dir_z
);

    localparam int PW = 2 * CORDIC_BITS;
    localparam int OW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (SH - 1);
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;
    localparam logic signed [OW-1:0] SAT = OW'(ONE);

    logic  w_go;
    logic  w_v;
    logic  w_vp;
    logic  w_vy;
    t_cval w_sr, w_cr, w_sp, w_cp, w_sy, w_cy;

    assign busy = 1'b0;
    assign w_go = start & ~busy;

    efd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_go), .i_angle(i_roll_angle),
        .o_valid(w_v), .o_sin(w_sr), .o_cos(w_cr));
    efd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_go), .i_angle(i_pitch_angle),
        .o_valid(w_vp), .o_sin(w_sp), .o_cos(w_cp));
    efd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_go), .i_angle(i_yaw_angle),
        .o_valid(w_vy), .o_sin(w_sy), .o_cos(w_cy));

    // stage 1: sp*sr, cy*cr, sy*cr, cp*sr
    logic  r_v1, r_v2, r_v3, r_v4;
    t_cval r_spsr, r_cycr, r_sycr, r_cpsr, r_sy1, r_cy1;
    // stage 2: products with spsr
    t_cval r_a, r_b, r_cycr2, r_sycr2, r_cpsr2;
    // stage 3: sums
    logic signed [PW-1:0] r_sx, r_sy, r_sz;
    logic signed [OW-1:0] r_ox, r_oy, r_oz;

    function automatic t_cval mulq(input t_cval a, input t_cval b);
        logic signed [PW-1:0] p;
        p = a * b;
        return t_cval'(p >>> 30);
    endfunction

    function automatic logic signed [OW-1:0] to_out(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + RND) >>> SH;
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return r[OW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spsr  <= mulq(w_sp, w_sr);
        r_cycr  <= mulq(w_cy, w_cr);
        r_sycr  <= mulq(w_sy, w_cr);
        r_cpsr  <= mulq(w_cp, w_sr);
        r_sy1   <= w_sy;
        r_cy1   <= w_cy;
        r_a     <= mulq(r_cy1, r_spsr);
        r_b     <= mulq(r_sy1, r_spsr);
        r_cycr2 <= r_cycr;
        r_sycr2 <= r_sycr;
        r_cpsr2 <= r_cpsr;
        r_sx    <= PW'(r_a) - PW'(r_sycr2);
        r_sy    <= PW'(r_b) + PW'(r_cycr2);
        r_sz    <= PW'(r_cpsr2);
        r_ox    <= to_out(r_sx);
        r_oy    <= to_out(r_sy);
        r_oz    <= to_out(r_sz);
    end

    assign o_valid = r_v4;
    assign o_dir_x = r_ox;
    assign o_dir_y = r_oy;
    assign o_dir_z = r_oz;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v == w_vp && w_v == w_vy)
        else $error("cordic lanes out of step");

    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= SAT && o_dir_x >= -SAT))
        else $error("dir_x not saturated");

    a_sat_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_y <= SAT && o_dir_y >= -SAT))
        else $error("dir_y not saturated");

endmodule
`default_nettype wire
